FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the ready-list scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RRRL_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("scheduler assertion failed");
`define RRRL_ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("scheduler forbidden condition seen");
`else
`define RRRL_ASSERT(lbl, ck, rs, prop)
`define RRRL_ASSERT_NEVER(lbl, ck, rs, cond)
`endif
`endif

FILE: hw/rtl/rrrl_pkg.sv
// Shared constants, types and helpers of the ready-list scheduler.
`default_nettype none
package rrrl_pkg;
  localparam int NUM_THREADS = 64;
  localparam int ID_W        = 6;
  localparam int IDX_W       = $clog2(NUM_THREADS);
  localparam int LINK_W      = $clog2(NUM_THREADS + 1);
  localparam int SLICE_W     = 32;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WAKE  = 2'd1;
  localparam logic [1:0] OP_SLEEP = 2'd2;
  localparam logic [1:0] OP_KICK  = 2'd3;

  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ID_W-1:0]    tid_t;
  typedef logic [SLICE_W-1:0] slice_t;

  localparam link_t LINK_NONE = link_t'(NUM_THREADS);

  typedef struct packed {
    logic bump;
    idx_t idx;
  } slice_req_t;

  function automatic logic link_ok(link_t l);
    return l < LINK_NONE;
  endfunction

  function automatic idx_t link_idx(link_t l);
    return l[IDX_W-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/rrrl_cmd_if.sv
// Command channel: opcode and thread slot with valid/ready.
`default_nettype none
interface rrrl_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  rrrl_pkg::tid_t    thread_id;

  modport source (output valid, opcode, thread_id, input ready);
  modport sink (input valid, opcode, thread_id, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rrrl_res_if.sv
// Result channel: running thread, its slice count and status with valid/ready.
`default_nettype none
interface rrrl_res_if;
  logic              valid;
  logic              ready;
  logic              idle;
  rrrl_pkg::tid_t    running_id;
  rrrl_pkg::slice_t  slice_count;
  logic              status;

  modport source (output valid, idle, running_id, slice_count, status, input ready);
  modport sink (input valid, idle, running_id, slice_count, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rrrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rrrl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rrrl_slice.sv
// Per-thread slice counters: read, saturating increment and write back.
`default_nettype none
module rrrl_slice (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rrrl_pkg::slice_req_t req,
  output rrrl_pkg::slice_t          count
);
  logic [rrrl_pkg::NUM_THREADS-1:0] seen;
  logic                             pend;
  rrrl_pkg::idx_t                   pend_idx;
  logic                             rd_seen;
  rrrl_pkg::slice_t                 rd_data;
  rrrl_pkg::slice_t                 old_count;

  rrrl_ram #(
    .DEPTH(rrrl_pkg::NUM_THREADS),
    .WIDTH(rrrl_pkg::SLICE_W)
  ) u_mem (
    .clk   (clk),
    .we    (pend),
    .waddr (pend_idx),
    .wdata (count),
    .re    (req.bump),
    .raddr (req.idx),
    .rdata (rd_data)
  );

  // an entry never written since reset reads as zero
  assign old_count = rd_seen ? rd_data : '0;
  assign count = (old_count == '1) ? old_count : old_count + rrrl_pkg::slice_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      pend <= 1'b0;
    end else begin
      pend <= req.bump;
      if (pend) begin
        seen[pend_idx] <= 1'b1;
      end
    end
    if (req.bump) begin
      pend_idx <= req.idx;
      rd_seen  <= seen[req.idx];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rrrl_ctrl.sv
// Sequencer: ready-list link memories, list pointers, awake flags, result register.
`default_nettype none
module rrrl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire logic [1:0]           cmd_opcode,
  input  wire rrrl_pkg::tid_t       cmd_thread_id,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic                      res_idle,
  output rrrl_pkg::tid_t            res_running_id,
  output rrrl_pkg::slice_t          res_slice_count,
  output logic                      res_status,
  output rrrl_pkg::slice_req_t      slice_req,
  input  wire rrrl_pkg::slice_t     slice_count
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WAKE2  = 3'd1;
  localparam logic [2:0] S_TICK   = 3'd2;
  localparam logic [2:0] S_UNLINK = 3'd3;
  localparam logic [2:0] S_SLICE  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]                       st, st_next;
  logic [rrrl_pkg::NUM_THREADS-1:0] awake, awake_next;
  rrrl_pkg::link_t                  head, head_next;
  rrrl_pkg::link_t                  tail, tail_next;
  rrrl_pkg::link_t                  cur, cur_next;
  rrrl_pkg::link_t                  sel, sel_next;
  rrrl_pkg::link_t                  tid, tid_next;
  rrrl_pkg::slice_t                 cur_slice, cur_slice_next;
  logic                             status, status_next;
  logic                             out_load;

  logic             nxt_we, prv_we, link_re;
  rrrl_pkg::idx_t   nxt_waddr, prv_waddr, link_raddr;
  rrrl_pkg::link_t  nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;

  rrrl_ram #(
    .DEPTH(rrrl_pkg::NUM_THREADS),
    .WIDTH(rrrl_pkg::LINK_W)
  ) u_next (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (nxt_rdata)
  );

  rrrl_ram #(
    .DEPTH(rrrl_pkg::NUM_THREADS),
    .WIDTH(rrrl_pkg::LINK_W)
  ) u_prev (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (prv_rdata)
  );

  assign cmd_ready = (st == S_IDLE);

  always_comb begin
    rrrl_pkg::link_t t, n, p, hn, a;
    st_next        = st;
    awake_next     = awake;
    head_next      = head;
    tail_next      = tail;
    cur_next       = cur;
    sel_next       = sel;
    tid_next       = tid;
    cur_slice_next = cur_slice;
    status_next    = status;
    out_load       = 1'b0;
    nxt_we         = 1'b0;
    nxt_waddr      = '0;
    nxt_wdata      = rrrl_pkg::LINK_NONE;
    prv_we         = 1'b0;
    prv_waddr      = '0;
    prv_wdata      = rrrl_pkg::LINK_NONE;
    link_re        = 1'b0;
    link_raddr     = '0;
    slice_req      = '0;
    t  = rrrl_pkg::link_t'(cmd_thread_id);
    n  = nxt_rdata;
    p  = prv_rdata;
    hn = head;
    a  = rrrl_pkg::LINK_NONE;

    case (st)
      S_IDLE: begin
        if (cmd_valid) begin
          tid_next    = t;
          status_next = 1'b0;
          case (cmd_opcode)
            rrrl_pkg::OP_TICK: begin
              if (rrrl_pkg::link_ok(cur)) begin
                link_re    = 1'b1;
                link_raddr = rrrl_pkg::link_idx(cur);
                st_next    = S_TICK;
              end else if (rrrl_pkg::link_ok(head)) begin
                slice_req.bump = 1'b1;
                slice_req.idx  = rrrl_pkg::link_idx(head);
                sel_next       = head;
                st_next        = S_SLICE;
              end else begin
                st_next = S_DONE;
              end
            end
            rrrl_pkg::OP_WAKE: begin
              if (!rrrl_pkg::link_ok(t) || awake[rrrl_pkg::link_idx(t)]) begin
                status_next = 1'b1;
                st_next     = S_DONE;
              end else begin
                awake_next[rrrl_pkg::link_idx(t)] = 1'b1;
                nxt_we    = 1'b1;
                nxt_waddr = rrrl_pkg::link_idx(t);
                nxt_wdata = rrrl_pkg::LINK_NONE;
                prv_we    = 1'b1;
                prv_waddr = rrrl_pkg::link_idx(t);
                prv_wdata = tail;
                tail_next = t;
                sel_next  = tail;
                if (rrrl_pkg::link_ok(tail)) begin
                  st_next = S_WAKE2;
                end else begin
                  head_next = t;
                  st_next   = S_DONE;
                end
              end
            end
            rrrl_pkg::OP_SLEEP: begin
              if (!rrrl_pkg::link_ok(t) || !awake[rrrl_pkg::link_idx(t)]) begin
                status_next = 1'b1;
                st_next     = S_DONE;
              end else begin
                link_re    = 1'b1;
                link_raddr = rrrl_pkg::link_idx(t);
                st_next    = S_UNLINK;
              end
            end
            default: begin
              if (!rrrl_pkg::link_ok(cur) && rrrl_pkg::link_ok(head)) begin
                slice_req.bump = 1'b1;
                slice_req.idx  = rrrl_pkg::link_idx(head);
                sel_next       = head;
                st_next        = S_SLICE;
              end else begin
                status_next = 1'b1;
                st_next     = S_DONE;
              end
            end
          endcase
        end
      end
      S_WAKE2: begin
        // link the old tail forward to the new thread
        nxt_we    = 1'b1;
        nxt_waddr = rrrl_pkg::link_idx(sel);
        nxt_wdata = tid;
        st_next   = S_DONE;
      end
      S_TICK: begin
        if (!rrrl_pkg::link_ok(n)) begin
          n = head;
        end
        if (rrrl_pkg::link_ok(n)) begin
          slice_req.bump = 1'b1;
          slice_req.idx  = rrrl_pkg::link_idx(n);
          sel_next       = n;
          st_next        = S_SLICE;
        end else begin
          cur_next = rrrl_pkg::LINK_NONE;
          st_next  = S_DONE;
        end
      end
      S_UNLINK: begin
        awake_next[rrrl_pkg::link_idx(tid)] = 1'b0;
        if (rrrl_pkg::link_ok(n)) begin
          prv_we    = 1'b1;
          prv_waddr = rrrl_pkg::link_idx(n);
          prv_wdata = p;
        end else begin
          tail_next = p;
        end
        if (rrrl_pkg::link_ok(p)) begin
          nxt_we    = 1'b1;
          nxt_waddr = rrrl_pkg::link_idx(p);
          nxt_wdata = n;
        end else begin
          head_next = n;
          hn        = n;
        end
        st_next = S_DONE;
        if (tid == cur) begin
          // running thread left: move to its old successor, else the head
          a = rrrl_pkg::link_ok(n) ? n : hn;
          if (rrrl_pkg::link_ok(a)) begin
            slice_req.bump = 1'b1;
            slice_req.idx  = rrrl_pkg::link_idx(a);
            sel_next       = a;
            st_next        = S_SLICE;
          end else begin
            cur_next = rrrl_pkg::LINK_NONE;
          end
        end
      end
      S_SLICE: begin
        cur_next       = sel;
        cur_slice_next = slice_count;
        st_next        = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!res_valid || res_ready) begin
          out_load = 1'b1;
          st_next  = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      awake     <= '0;
      head      <= rrrl_pkg::LINK_NONE;
      tail      <= rrrl_pkg::LINK_NONE;
      cur       <= rrrl_pkg::LINK_NONE;
      res_valid <= 1'b0;
    end else begin
      st    <= st_next;
      awake <= awake_next;
      head  <= head_next;
      tail  <= tail_next;
      cur   <= cur_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    sel       <= sel_next;
    tid       <= tid_next;
    cur_slice <= cur_slice_next;
    status    <= status_next;
    if (out_load) begin
      res_idle        <= !rrrl_pkg::link_ok(cur);
      res_running_id  <= rrrl_pkg::link_ok(cur) ? cur[rrrl_pkg::ID_W-1:0] : '0;
      res_slice_count <= rrrl_pkg::link_ok(cur) ? cur_slice : '0;
      res_status      <= status;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/round_robin_ready_list.sv
// Top level of the round-robin ready-list scheduler.
`default_nettype none
`include "assert_macros.svh"
// Round-robin thread scheduler. Each cmd transaction (tick, wake, sleep, kick)
// yields exactly one res transaction with the running thread, its saturating
// slice count and a status bit (1 when a wake, sleep or kick had no effect).
// Commands are handled one at a time, in states set by the registered reads of
// the next/prev link RAMs and the read-increment-write of the slice counter RAM.
// An ignored command, a tick on an empty list and a wake onto an empty list go
// from S_IDLE straight to S_DONE; any other wake passes S_WAKE2, a sleep that
// does not select a thread S_UNLINK, and a tick or kick that starts from idle
// S_SLICE; a tick while a thread runs passes S_TICK and S_SLICE, and a sleep of
// the running thread that selects another S_UNLINK and S_SLICE. While the result
// register still holds an unread result, S_DONE waits until res takes it. The
// result register lets the next command be taken while a result still waits on
// res. No clearing pass is needed after reset.
module round_robin_ready_list (
  input wire logic   clk,
  input wire logic   rst,
  rrrl_cmd_if.sink   cmd,
  rrrl_res_if.source res
);
  rrrl_pkg::slice_req_t slice_req;
  rrrl_pkg::slice_t     slice_count;
  logic                 res_busy;
  logic                 res_dirty;

  rrrl_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_opcode      (cmd.opcode),
    .cmd_thread_id   (cmd.thread_id),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_idle        (res.idle),
    .res_running_id  (res.running_id),
    .res_slice_count (res.slice_count),
    .res_status      (res.status),
    .slice_req       (slice_req),
    .slice_count     (slice_count)
  );

  rrrl_slice u_slice (
    .clk   (clk),
    .rst   (rst),
    .req   (slice_req),
    .count (slice_count)
  );

  assign res_busy  = res.valid && !res.idle;
  assign res_dirty = (res.running_id != '0) || (res.slice_count != '0);

  `RRRL_ASSERT(a_busy_after_accept, clk, rst, (cmd.valid && cmd.ready) |=> !cmd.ready)
  `RRRL_ASSERT(a_running_was_counted, clk, rst, res_busy |-> (res.slice_count != '0))
  `RRRL_ASSERT_NEVER(a_idle_result_clean, clk, rst, res.valid && res.idle && res_dirty)
endmodule
`default_nettype wire

FILE: sim/rrrl_checker.sv
// Scoreboard for the ready-list scheduler: watches both channels, predicts and compares results.
module rrrl_checker
  import rrrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rrrl_cmd_if         cmd,
  rrrl_res_if         res,
  output int unsigned err_count,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic   idle;
    tid_t   running_id;
    slice_t slice_count;
    logic   status;
  } sched_out_t;

  // Shadow copy of the scheduler state
  logic   awake_map   [NUM_THREADS];
  link_t  succ_link   [NUM_THREADS];
  link_t  pred_link   [NUM_THREADS];
  slice_t slice_tally [NUM_THREADS];
  link_t  ready_head;
  link_t  ready_tail;
  link_t  run_slot;

  sched_out_t  sel_queue [$];
  int unsigned mismatches = 0;
  int unsigned n_results  = 0;

  function void clear_sched();
    for (int i = 0; i < NUM_THREADS; i++) begin
      awake_map[i]   = 1'b0;
      succ_link[i]   = LINK_NONE;
      pred_link[i]   = LINK_NONE;
      slice_tally[i] = '0;
    end
    ready_head = LINK_NONE;
    ready_tail = LINK_NONE;
    run_slot   = LINK_NONE;
  endfunction

  // Move to the successor of the running thread, wrap to the head, or go idle.
  function void select_next();
    link_t cand;
    cand = ready_head;
    if (run_slot < LINK_NONE) begin
      cand = succ_link[run_slot[IDX_W-1:0]];
      if (cand >= LINK_NONE) cand = ready_head;
    end
    if (cand >= LINK_NONE) begin
      run_slot = LINK_NONE;
    end else begin
      run_slot = cand;
      if (slice_tally[cand[IDX_W-1:0]] != '1)
        slice_tally[cand[IDX_W-1:0]] = slice_tally[cand[IDX_W-1:0]] + 1'b1;
    end
  endfunction

  function logic wake_thread(tid_t t);
    if (awake_map[t]) return 1'b1;
    awake_map[t] = 1'b1;
    succ_link[t] = LINK_NONE;
    pred_link[t] = ready_tail;
    if (ready_tail < LINK_NONE) succ_link[ready_tail[IDX_W-1:0]] = link_t'(t);
    else ready_head = link_t'(t);
    ready_tail = link_t'(t);
    return 1'b0;
  endfunction

  function logic sleep_thread(tid_t t);
    link_t nx;
    link_t pv;
    if (!awake_map[t]) return 1'b1;
    awake_map[t] = 1'b0;
    nx = succ_link[t];
    pv = pred_link[t];
    if (nx < LINK_NONE) pred_link[nx[IDX_W-1:0]] = pv;
    else ready_tail = pv;
    if (pv < LINK_NONE) succ_link[pv[IDX_W-1:0]] = nx;
    else ready_head = nx;
    // the sleeper's own links stay intact, so its old successor is still found
    if (link_t'(t) == run_slot) select_next();
    return 1'b0;
  endfunction

  function sched_out_t schedule_step(logic [1:0] op, tid_t tid);
    logic       st;
    sched_out_t r;
    st = 1'b0;
    case (op)
      OP_TICK:  select_next();
      OP_WAKE:  st = wake_thread(tid);
      OP_SLEEP: st = sleep_thread(tid);
      OP_KICK: begin
        if (run_slot >= LINK_NONE && ready_head < LINK_NONE) select_next();
        else st = 1'b1;
      end
      default: ;
    endcase
    if (run_slot < LINK_NONE) begin
      r.idle        = 1'b0;
      r.running_id  = run_slot[IDX_W-1:0];
      r.slice_count = slice_tally[run_slot[IDX_W-1:0]];
    end else begin
      r.idle        = 1'b1;
      r.running_id  = '0;
      r.slice_count = '0;
    end
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < 100)
      $display("[%0t] result %0d: %0s got 0x%0h expected 0x%0h",
               $time, n_results, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    sched_out_t want;
    if (rst) begin
      clear_sched();
      sel_queue.delete();
    end else begin
      if (res.valid && res.ready) begin
        n_results++;
        if (sel_queue.size() == 0) begin
          report_mismatch("result with no command pending, running_id", res.running_id, 0);
        end else begin
          want = sel_queue.pop_front();
          if (res.idle !== want.idle)
            report_mismatch("idle", res.idle, want.idle);
          if (res.running_id !== want.running_id)
            report_mismatch("running_id", res.running_id, want.running_id);
          if (res.slice_count !== want.slice_count)
            report_mismatch("slice_count", res.slice_count, want.slice_count);
          if (res.status !== want.status)
            report_mismatch("status", res.status, want.status);
        end
      end
      if (cmd.valid && cmd.ready)
        sel_queue.push_back(schedule_step(cmd.opcode, cmd.thread_id));
    end
    err_count   <= mismatches;
    outstanding <= sel_queue.size();
  end
endmodule

FILE: sim/testbench.sv
// Top of the ready-list scheduler testbench: clock, reset, command stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rrrl_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned N_PHASES     = 8;
  localparam int unsigned QUIET_LIMIT  = 1000;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned err_count;
  int unsigned outstanding;

  int unsigned phase_send [4] = '{0, 57, 0, 32};
  int unsigned phase_recv [4] = '{0, 0, 57, 32};
  int unsigned phase_pool [4] = '{7, 15, 63, 11};

  rrrl_cmd_if cmd_ch ();
  rrrl_res_if res_ch ();

  round_robin_ready_list u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  rrrl_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .err_count   (err_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [1:0] op, input tid_t tid);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.opcode    <= op;
    cmd_ch.thread_id <= tid;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic send_random(input int unsigned pool_hi);
    int unsigned pick;
    tid_t        tid;
    pick = $urandom_range(99);
    // favor a small pool of slots so wakes and sleeps collide often
    if ($urandom_range(99) < 65) tid = tid_t'($urandom_range(pool_hi));
    else tid = tid_t'($urandom());
    if (pick < 35)      send_cmd(OP_WAKE, tid);
    else if (pick < 60) send_cmd(OP_SLEEP, tid);
    else if (pick < 90) send_cmd(OP_TICK, tid);
    else                send_cmd(OP_KICK, tid);
  endtask

  initial begin
    rst              <= 1'b1;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.opcode    <= OP_TICK;
    cmd_ch.thread_id <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // tick and kick on an empty list, sleep of a thread never woken
    send_cmd(OP_TICK, 6'd63);
    send_cmd(OP_KICK, 6'd0);
    send_cmd(OP_SLEEP, 6'd5);
    send_cmd(OP_WAKE, 6'd63);
    send_cmd(OP_WAKE, 6'd0);
    // wake of an awake thread
    send_cmd(OP_WAKE, 6'd63);
    send_cmd(OP_KICK, 6'd21);
    // kick while a thread runs
    send_cmd(OP_KICK, 6'd42);
    send_cmd(OP_WAKE, 6'd42);
    send_cmd(OP_TICK, 6'd0);
    send_cmd(OP_TICK, 6'd0);
    // wrap from the tail to the head
    send_cmd(OP_TICK, 6'd0);
    // sleep of a thread that is not running, then of the running one
    send_cmd(OP_SLEEP, 6'd0);
    send_cmd(OP_SLEEP, 6'd63);
    send_cmd(OP_SLEEP, 6'd42);
    send_cmd(OP_TICK, 6'd21);
    // wake again after sleeping: stale links must be replaced
    send_cmd(OP_WAKE, 6'd42);
    send_cmd(OP_WAKE, 6'd21);
    send_cmd(OP_KICK, 6'd0);
    send_cmd(OP_SLEEP, 6'd21);
    send_cmd(OP_TICK, 6'd0);
    send_cmd(OP_SLEEP, 6'd42);
    send_cmd(OP_SLEEP, 6'd42);
    send_cmd(OP_KICK, 6'd63);

    for (int p = 0; p < N_PHASES; p++) begin
      send_idle_pct  = phase_send[p % 4];
      recv_stall_pct <= phase_recv[p % 4];
      for (int n = 0; n < RANDOM_ITEMS / N_PHASES; n++) begin
        if ($urandom_range(99) < 2) begin
          // sleep every slot of the pool, then try to restart the list
          for (int t = 0; t <= phase_pool[p % 4]; t++) send_cmd(OP_SLEEP, tid_t'(t));
          send_cmd(OP_KICK, tid_t'($urandom()));
        end else begin
          send_random(phase_pool[p % 4]);
        end
      end
    end
    cmd_ch.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (err_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
